[rtl/core/fre_pkg.sv]
// Shared constants, codes and helper functions of the field rotation estimator.
package fre_pkg;

   localparam int DEF_MAX_POINTS   = 16;
   localparam int DEF_COORD_BITS   = 24;
   localparam int DEF_CORDIC_ITERS = 24;

   localparam int ANGLE_BITS  = 30;
   localparam int TOL_BITS    = 29;
   localparam int MINP_BITS   = 5;
   localparam int STATUS_BITS = 2;
   localparam int CSR_DATA_BITS = 29;
   localparam int CSR_ADDR_BITS = 2;
   localparam int QUOT_BITS   = 31;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_NEGATE    = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TOLERANCE = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MIN_POINTS = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FEW      = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO_WT  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd3;

   localparam logic [MINP_BITS-1:0] MIN_POINTS_RESET = 5'd3;

   localparam logic [31:0] MAS_PER_TURN = 32'd1296000000;
   localparam logic [31:0] HALF_TURN_Z  = 32'h8000_0000;
   localparam logic signed [32:0] QUARTER_TURN = 33'sh0_4000_0000;
   localparam logic signed [32:0] HALF_TURN    = 33'sh0_8000_0000;

   // Arctangent of 2^-i in binary-angle units (2^32 per turn).
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   // Brings an angle back into plus or minus a quarter turn.
   function automatic logic signed [32:0] fold_angle(input logic signed [32:0] a);
      logic signed [32:0] r;
      if (a > QUARTER_TURN) begin
         r = a - HALF_TURN;
      end else if (a < -QUARTER_TURN) begin
         r = a + HALF_TURN;
      end else begin
         r = a;
      end
      return r;
   endfunction

endpackage

[rtl/core/field_rotation_estimator_top.sv]
// Field rotation estimator: point store, shared CORDIC, multiplier and divider sequencer.
// A point without the last flag is only stored; a point with it is taken as well and then,
// when the status can still come out ok, runs over all P = N*(N-1)/2 pairs of N points.
// Throughput: one point per cycle while loading; one result per set, bounded by the single
// CORDIC vectoring unit that is run twice per pair and the bit-serial divider (31 steps).
// Reset (synchronous, active high) empties the store count, clears the overflow mark and the
// output valid, and sets the registers to negate 0, tolerance 0 and minimum points 3.
module field_rotation_estimator_top #(
   parameter int MAX_POINTS   = fre_pkg::DEF_MAX_POINTS,
   parameter int COORD_BITS   = fre_pkg::DEF_COORD_BITS,
   parameter int CORDIC_ITERS = fre_pkg::DEF_CORDIC_ITERS,
   parameter int REQ_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [fre_pkg::CSR_ADDR_BITS-1:0]      csr_addr,
   input  logic [fre_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0 up: star_x, star_y, meas_x, meas_y, zero fill.
   input  logic [REQ_DATA_BITS-1:0]               req_tdata,
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // Fields from bit 0 up: angle_mas, zero fill.
   output logic [31:0]                            rsp_tdata,
   // Fields from bit 0 up: adjust, status.
   output logic [2:0]                             rsp_tuser
);

   localparam int C       = COORD_BITS;
   localparam int D       = C + 1;               // difference of two coordinates
   localparam int CW      = C + 4;               // CORDIC datapath with gain headroom
   localparam int W_W     = 2 * C + 2;           // squared separation
   localparam int IDX_W   = $clog2(MAX_POINTS);
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int CMP_W   = (CNT_W > fre_pkg::MINP_BITS) ? CNT_W : fre_pkg::MINP_BITS;
   localparam int PAIRS   = MAX_POINTS * (MAX_POINTS - 1) / 2;
   localparam int PAIR_B  = $clog2(PAIRS + 1);
   localparam int PROD_W  = W_W + fre_pkg::QUOT_BITS;
   localparam int ACC_W   = PROD_W + PAIR_B;
   localparam int TOT_W   = W_W + PAIR_B;
   localparam int DIV_W   = ACC_W + 1;
   localparam int IT_W    = $clog2(CORDIC_ITERS + 1);
   localparam int PT_W    = 4 * C;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_RD_I   = 14'b00000000000010,
      ST_RD_J   = 14'b00000000000100,
      ST_DIFF   = 14'b00000000001000,
      ST_SQX    = 14'b00000000010000,
      ST_SQY    = 14'b00000000100000,
      ST_CINIT  = 14'b00000001000000,
      ST_CORD   = 14'b00000010000000,
      ST_ANGLE  = 14'b00000100000000,
      ST_MUL_LO = 14'b00001000000000,
      ST_MUL_HI = 14'b00010000000000,
      ST_ACC    = 14'b00100000000000,
      ST_DIV    = 14'b01000000000000,
      ST_SCALE  = 14'b10000000000000
   } state_type;

   // Finishing steps reuse one register of their own so the enum stays small.
   typedef enum logic [3:0] {
      FIN_NONE  = 4'b0001,
      FIN_EVAL  = 4'b0010,
      FIN_SCALE = 4'b0100,
      FIN_DONE  = 4'b1000
   } fin_type;

   state_type state_ff, state_in;
   fin_type   fin_ff, fin_in;

   logic                               negate_ff, negate_in;
   logic [fre_pkg::TOL_BITS-1:0]       tol_ff, tol_in;
   logic [fre_pkg::MINP_BITS-1:0]      minp_ff, minp_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [IDX_W-1:0]  pi_idx_ff, pi_idx_in, pj_idx_ff, pj_idx_in;

   logic [PT_W-1:0]   store_mem [MAX_POINTS];
   logic [PT_W-1:0]   rd_data_ff;
   logic [PT_W-1:0]   pt_i_ff, pt_i_in;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;

   logic signed [D-1:0] dxr_ff, dxr_in, dyr_ff, dyr_in, dxm_ff, dxm_in, dym_ff, dym_in;
   logic [W_W-1:0]      sq_ff, sq_in, w_ff, w_in;

   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [31:0]          cz_ff, cz_in;
   logic                 cskip_ff, cskip_in, csel_ff, csel_in;
   logic [IT_W-1:0]      iter_ff, iter_in;
   logic signed [32:0]   tr_ff, tr_in, tm_ff, tm_in;

   logic [30:0]          dmag_ff, dmag_in;
   logic                 dpos_ff, dpos_in, dneg_ff, dneg_in;
   logic [63:0]          plo_ff, plo_in;

   logic [31:0]          mul_a, mul_b;
   logic [63:0]          mul_p_ff;

   logic [ACC_W-1:0]     pos_ff, pos_in, neg_ff, neg_in;
   logic [TOT_W-1:0]     tot_ff, tot_in;
   logic [DIV_W-1:0]     mag_ff, mag_in, sh_ff, sh_in;
   logic [fre_pkg::QUOT_BITS-1:0] q_ff, q_in;
   logic [4:0]           bit_ff, bit_in;
   logic                 sign_ff, sign_in;

   logic [fre_pkg::ANGLE_BITS-1:0]  res_angle_ff, res_angle_in;
   logic                            res_adj_ff, res_adj_in;
   logic [fre_pkg::STATUS_BITS-1:0] res_st_ff, res_st_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fre_pkg::ANGLE_BITS-1:0]  rsp_angle_ff, rsp_angle_in;
   logic                            rsp_adj_ff, rsp_adj_in;
   logic [fre_pkg::STATUS_BITS-1:0] rsp_st_ff, rsp_st_in;

   function automatic logic [D-1:0] mag_of(input logic signed [D-1:0] v);
      return v[D-1] ? D'(-v) : D'(v);
   endfunction

   function automatic logic signed [D-1:0] coord_diff(input logic [C-1:0] a,
                                                       input logic [C-1:0] b);
      return $signed({a[C-1], a}) - $signed({b[C-1], b});
   endfunction

   assign req_tready = (state_ff == ST_IDLE) && (fin_ff == FIN_NONE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32 - fre_pkg::ANGLE_BITS){1'b0}}, rsp_angle_ff};
   assign rsp_tuser  = {rsp_st_ff, rsp_adj_ff};

   assign wr_en   = req_tvalid && req_tready && (count_ff < CNT_W'(MAX_POINTS));
   assign rd_addr = (state_ff == ST_RD_I) ? pi_idx_ff : pj_idx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[count_ff[IDX_W-1:0]] <= req_tdata[PT_W-1:0];
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // The one multiplier, shared by the squares, the weighted angles and the scaling.
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (state_ff)
         ST_SQX: begin
            mul_a = 32'(mag_of(dxr_ff));
            mul_b = 32'(mag_of(dxr_ff));
         end
         ST_SQY: begin
            mul_a = 32'(mag_of(dyr_ff));
            mul_b = 32'(mag_of(dyr_ff));
         end
         ST_MUL_LO: begin
            mul_a = 32'(dmag_ff);
            mul_b = 32'(64'(w_ff));
         end
         ST_MUL_HI: begin
            mul_a = 32'(dmag_ff);
            mul_b = 32'(64'(w_ff) >> 32);
         end
         ST_SCALE: begin
            mul_a = 32'(q_ff);
            mul_b = fre_pkg::MAS_PER_TURN;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
   end

   always_comb begin
      logic signed [CW-1:0] xs, ys, x0, y0;
      logic [31:0]          z_next, zfin;
      logic                 last_it;
      logic signed [32:0]   ang, dd;
      logic [PROD_W-1:0]    prod;
      logic [CNT_W-1:0]     cnt_new;
      logic                 ovf_new;
      logic [63:0]          scaled;
      logic [fre_pkg::ANGLE_BITS-1:0] m;
      logic                 neg_out;

      state_in = state_ff;
      fin_in = fin_ff;
      negate_in = negate_ff;
      tol_in = tol_ff;
      minp_in = minp_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      pi_idx_in = pi_idx_ff;
      pj_idx_in = pj_idx_ff;
      pt_i_in = pt_i_ff;
      dxr_in = dxr_ff;
      dyr_in = dyr_ff;
      dxm_in = dxm_ff;
      dym_in = dym_ff;
      sq_in = sq_ff;
      w_in = w_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      cskip_in = cskip_ff;
      csel_in = csel_ff;
      iter_in = iter_ff;
      tr_in = tr_ff;
      tm_in = tm_ff;
      dmag_in = dmag_ff;
      dpos_in = dpos_ff;
      dneg_in = dneg_ff;
      plo_in = plo_ff;
      pos_in = pos_ff;
      neg_in = neg_ff;
      tot_in = tot_ff;
      mag_in = mag_ff;
      sh_in = sh_ff;
      q_in = q_ff;
      bit_in = bit_ff;
      sign_in = sign_ff;
      res_angle_in = res_angle_ff;
      res_adj_in = res_adj_ff;
      res_st_in = res_st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_adj_in = rsp_adj_ff;
      rsp_st_in = rsp_st_ff;

      xs = cx_ff >>> 5'(iter_ff);
      ys = cy_ff >>> 5'(iter_ff);
      x0 = '0;
      y0 = '0;
      z_next = cz_ff;
      zfin = cz_ff;
      last_it = 1'b0;
      ang = '0;
      dd = '0;
      prod = '0;
      cnt_new = count_ff;
      ovf_new = ovf_ff;
      scaled = mul_p_ff;
      m = '0;
      neg_out = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_addr)
            fre_pkg::CSR_NEGATE:     negate_in = csr_wdata[0];
            fre_pkg::CSR_TOLERANCE:  tol_in = csr_wdata[fre_pkg::TOL_BITS-1:0];
            fre_pkg::CSR_MIN_POINTS: minp_in = csr_wdata[fre_pkg::MINP_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            case (fin_ff)
               FIN_EVAL: begin
                  // Status precedence: overflow, too few points, zero weight.
                  res_angle_in = '0;
                  res_adj_in = 1'b0;
                  if (ovf_ff) begin
                     res_st_in = fre_pkg::STATUS_OVERFLOW;
                     fin_in = FIN_DONE;
                  end else if (CMP_W'(count_ff) < CMP_W'(minp_ff)) begin
                     res_st_in = fre_pkg::STATUS_FEW;
                     fin_in = FIN_DONE;
                  end else if (tot_ff == '0) begin
                     res_st_in = fre_pkg::STATUS_ZERO_WT;
                     fin_in = FIN_DONE;
                  end else begin
                     res_st_in = fre_pkg::STATUS_OK;
                     sign_in = pos_ff < neg_ff;
                     mag_in = (pos_ff < neg_ff) ? DIV_W'(neg_ff - pos_ff)
                                                : DIV_W'(pos_ff - neg_ff);
                     sh_in = DIV_W'(tot_ff) << 30;
                     q_in = '0;
                     bit_in = 5'd30;
                     state_in = ST_DIV;
                  end
               end
               FIN_SCALE: begin
                  m = scaled[32 +: fre_pkg::ANGLE_BITS];
                  res_adj_in = m >= fre_pkg::ANGLE_BITS'(tol_ff);
                  neg_out = sign_ff ^ negate_ff;
                  res_angle_in = neg_out ? -m : m;
                  fin_in = FIN_DONE;
               end
               FIN_DONE: begin
                  if (!rsp_valid_ff || rsp_tready) begin
                     rsp_valid_in = 1'b1;
                     rsp_angle_in = res_angle_ff;
                     rsp_adj_in = res_adj_ff;
                     rsp_st_in = res_st_ff;
                     count_in = '0;
                     ovf_in = 1'b0;
                     fin_in = FIN_NONE;
                  end
               end
               default: begin
                  if (req_tvalid) begin
                     if (count_ff < CNT_W'(MAX_POINTS)) begin
                        cnt_new = count_ff + CNT_W'(1);
                     end else begin
                        ovf_new = 1'b1;
                     end
                     count_in = cnt_new;
                     ovf_in = ovf_new;
                     if (req_tlast) begin
                        pos_in = '0;
                        neg_in = '0;
                        tot_in = '0;
                        pi_idx_in = '0;
                        pj_idx_in = IDX_W'(1);
                        // Pairs only matter when the status can still come out ok.
                        if (!ovf_new && !(CMP_W'(cnt_new) < CMP_W'(minp_ff))
                            && cnt_new >= CNT_W'(2)) begin
                           state_in = ST_RD_I;
                        end else begin
                           fin_in = FIN_EVAL;
                        end
                     end
                  end
               end
            endcase
         end
         ST_RD_I: state_in = ST_RD_J;
         ST_RD_J: begin
            pt_i_in = rd_data_ff;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            dxr_in = coord_diff(pt_i_ff[0 +: C], rd_data_ff[0 +: C]);
            dyr_in = coord_diff(pt_i_ff[C +: C], rd_data_ff[C +: C]);
            dxm_in = coord_diff(pt_i_ff[2*C +: C], rd_data_ff[2*C +: C]);
            dym_in = coord_diff(pt_i_ff[3*C +: C], rd_data_ff[3*C +: C]);
            state_in = ST_SQX;
         end
         ST_SQX: state_in = ST_SQY;
         ST_SQY: begin
            sq_in = W_W'(mul_p_ff);
            csel_in = 1'b0;
            state_in = ST_CINIT;
         end
         ST_CINIT: begin
            if (!csel_ff) begin
               w_in = sq_ff + W_W'(mul_p_ff);
               x0 = CW'(dxr_ff);
               y0 = CW'(dyr_ff);
            end else begin
               x0 = CW'(dxm_ff);
               y0 = CW'(dym_ff);
            end
            // A vector in the left half plane is turned by half a turn first.
            if (x0 < 0) begin
               cx_in = -x0;
               cy_in = -y0;
               cz_in = fre_pkg::HALF_TURN_Z;
            end else begin
               cx_in = x0;
               cy_in = y0;
               cz_in = '0;
            end
            cskip_in = (y0 == 0);
            iter_in = '0;
            state_in = ST_CORD;
         end
         ST_CORD: begin
            last_it = cskip_ff || (iter_ff == IT_W'(CORDIC_ITERS - 1));
            if (!cskip_ff) begin
               if (cy_ff < 0) begin
                  cx_in = cx_ff - ys;
                  cy_in = cy_ff + xs;
                  z_next = cz_ff - fre_pkg::atan_entry(5'(iter_ff));
               end else begin
                  cx_in = cx_ff + ys;
                  cy_in = cy_ff - xs;
                  z_next = cz_ff + fre_pkg::atan_entry(5'(iter_ff));
               end
               cz_in = z_next;
               iter_in = iter_ff + IT_W'(1);
            end
            zfin = z_next;
            if (last_it) begin
               ang = fre_pkg::fold_angle(33'($signed(zfin)));
               if (!csel_ff) begin
                  tr_in = ang;
                  csel_in = 1'b1;
                  state_in = ST_CINIT;
               end else begin
                  tm_in = ang;
                  state_in = ST_ANGLE;
               end
            end
         end
         ST_ANGLE: begin
            dd = fre_pkg::fold_angle(tm_ff - tr_ff);
            dpos_in = dd > 0;
            dneg_in = dd < 0;
            dmag_in = dd[32] ? 31'(-dd) : 31'(dd);
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: begin
            plo_in = mul_p_ff;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            prod = PROD_W'(plo_ff) + (PROD_W'(mul_p_ff) << 32);
            tot_in = tot_ff + TOT_W'(w_ff);
            if (dpos_ff) begin
               pos_in = pos_ff + ACC_W'(prod);
            end else if (dneg_ff) begin
               neg_in = neg_ff + ACC_W'(prod);
            end
            if (CNT_W'(pj_idx_ff) + CNT_W'(1) < count_ff) begin
               pj_idx_in = pj_idx_ff + IDX_W'(1);
               state_in = ST_RD_I;
            end else if (CNT_W'(pi_idx_ff) + CNT_W'(2) < count_ff) begin
               pi_idx_in = pi_idx_ff + IDX_W'(1);
               pj_idx_in = pi_idx_ff + IDX_W'(2);
               state_in = ST_RD_I;
            end else begin
               state_in = ST_IDLE;
               fin_in = FIN_EVAL;
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle from the top.
            if (mag_ff >= sh_ff) begin
               mag_in = mag_ff - sh_ff;
               q_in = {q_ff[fre_pkg::QUOT_BITS-2:0], 1'b1};
            end else begin
               q_in = {q_ff[fre_pkg::QUOT_BITS-2:0], 1'b0};
            end
            sh_in = sh_ff >> 1;
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_IDLE;
            fin_in = FIN_SCALE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff <= FIN_NONE;
         negate_ff <= 1'b0;
         tol_ff <= '0;
         minp_ff <= fre_pkg::MIN_POINTS_RESET;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff <= fin_in;
         negate_ff <= negate_in;
         tol_ff <= tol_in;
         minp_ff <= minp_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pi_idx_ff <= pi_idx_in;
      pj_idx_ff <= pj_idx_in;
      pt_i_ff <= pt_i_in;
      dxr_ff <= dxr_in;
      dyr_ff <= dyr_in;
      dxm_ff <= dxm_in;
      dym_ff <= dym_in;
      sq_ff <= sq_in;
      w_ff <= w_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      cskip_ff <= cskip_in;
      csel_ff <= csel_in;
      iter_ff <= iter_in;
      tr_ff <= tr_in;
      tm_ff <= tm_in;
      dmag_ff <= dmag_in;
      dpos_ff <= dpos_in;
      dneg_ff <= dneg_in;
      plo_ff <= plo_in;
      pos_ff <= pos_in;
      neg_ff <= neg_in;
      tot_ff <= tot_in;
      mag_ff <= mag_in;
      sh_ff <= sh_in;
      q_ff <= q_in;
      bit_ff <= bit_in;
      sign_ff <= sign_in;
      res_angle_ff <= res_angle_in;
      res_adj_ff <= res_adj_in;
      res_st_ff <= res_st_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_adj_ff <= rsp_adj_in;
      rsp_st_ff <= rsp_st_in;
   end

endmodule
